@@ rtl/core/vertex_transform_4x4_assert.svh @@
// Assertion macros for the vertex transform checker.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef VERTEX_TRANSFORM_4X4_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_ASSERT_SVH

// Same-cycle implication, quiet while in reset.
`define VT4_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

// Next-cycle implication, quiet while in reset.
`define VT4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) else $error(msg);

`endif

@@ rtl/core/vt4_pkg.sv @@
// Shared types and constants for the 4x4 vertex transform.
// No dependencies; used by every module of the block.
package vt4_pkg;

  localparam int NCOL      = 4;   // vertex components per item
  localparam int LANES     = 4;   // one lane per matrix row
  localparam int COEF_W    = 16;  // Q3.12 coefficient
  localparam int COMP_W    = 32;  // Q16.16 vertex component
  localparam int ROW_W     = NCOL * COEF_W;
  localparam int PROD_W    = COEF_W + COMP_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 3;
  localparam int QUOT_W    = SUM_W - 12;
  localparam int FRAC_SHIFT = 12;
  localparam int ROUND_HALF = 2048;
  localparam int CFG_IDX_W = 3;
  localparam int LATENCY   = 4;   // accept edge to result strobe

  // Reset matrix is the identity.
  localparam logic [ROW_W-1:0] ROW_RESET [LANES] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_1000_0000,
    64'h0000_1000_0000_0000,
    64'h1000_0000_0000_0000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0,
    CFG_ROW1,
    CFG_ROW2,
    CFG_ROW3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] in_x;
    logic signed [COMP_W-1:0] in_y;
    logic signed [COMP_W-1:0] in_z;
    logic signed [COMP_W-1:0] in_w;
  } vt4_in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic signed [COMP_W-1:0] out_w;
    logic                     saturated;
  } vt4_out_t;

  // What one row lane hands to the merge stage.
  typedef struct packed {
    logic signed [COMP_W-1:0] val;
    logic                     sat;
  } vt4_lane_res_t;

  typedef logic [COMP_W-1:0] comp_vec_t [NCOL];

endpackage

@@ rtl/core/vt4_lane.sv @@
// One matrix row lane: four products, pair sums, final sum, round and saturate.
// Depends on vt4_pkg.
module vt4_lane
  import vt4_pkg::*;
(
  input  logic             clk,
  input  logic [ROW_W-1:0] coefs,
  input  comp_vec_t        vec,
  output vt4_lane_res_t    res
);

  logic signed [PROD_W-1:0] prod_r [NCOL];
  logic signed [PAIR_W-1:0] pair_r [2];
  logic signed [SUM_W-1:0]  sum;
  logic signed [QUOT_W-1:0] quot;
  logic                     pos_ovf;
  logic                     neg_ovf;
  vt4_lane_res_t            res_nxt;
  vt4_lane_res_t            res_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCOL; c++) begin
      prod_r[c] <= $signed(coefs[c*COEF_W +: COEF_W]) * $signed(vec[c]);
    end
    pair_r[0] <= PAIR_W'(prod_r[0]) + PAIR_W'(prod_r[1]);
    pair_r[1] <= PAIR_W'(prod_r[2]) + PAIR_W'(prod_r[3]);
    res_r     <= res_nxt;
  end

  // Round half up: add half an LSB, then floor by arithmetic shift.
  always_comb begin
    sum     = SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]) + SUM_W'(ROUND_HALF);
    quot    = sum[SUM_W-1:FRAC_SHIFT];
    pos_ovf = !quot[QUOT_W-1] && (|quot[QUOT_W-2:COMP_W-1]);
    neg_ovf = quot[QUOT_W-1] && !(&quot[QUOT_W-2:COMP_W-1]);
    res_nxt.sat = pos_ovf || neg_ovf;
    if (pos_ovf) begin
      res_nxt.val = {1'b0, {(COMP_W-1){1'b1}}};
    end else if (neg_ovf) begin
      res_nxt.val = {1'b1, {(COMP_W-1){1'b0}}};
    end else begin
      res_nxt.val = quot[COMP_W-1:0];
    end
  end

  assign res = res_r;

endmodule

@@ rtl/core/vt4_merge.sv @@
// Merge stage: packs the four lane results into one item and gathers saturation.
// Depends on vt4_pkg.
module vt4_merge
  import vt4_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          lane_valid,
  input  vt4_lane_res_t lane_res [LANES],
  output logic          out_strobe,
  output vt4_out_t      out_item
);

  logic     strobe_r;
  vt4_out_t item_r;
  vt4_out_t item_nxt;

  always_comb begin
    item_nxt.out_x     = lane_res[0].val;
    item_nxt.out_y     = lane_res[1].val;
    item_nxt.out_z     = lane_res[2].val;
    item_nxt.out_w     = lane_res[3].val;
    item_nxt.saturated = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      item_nxt.saturated = item_nxt.saturated | lane_res[l].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= lane_valid;
    end
    item_r <= item_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

@@ rtl/core/vertex_transform_4x4.sv @@
// Top level of the 4x4 vertex transform: matrix registers, row lanes, merge.
// Depends on vt4_pkg, vt4_lane and vt4_merge.
//
// Takes one vertex per clock and never stalls: busy stays low, so an item is
// accepted on every edge with start high. Each item's result appears on
// out_item, flagged by out_strobe for one cycle, once it has passed the
// four register stages (multiply, pair add, final add with round and
// saturate, merge). The receiver cannot hold results off and must take each
// one as it is strobed. Matrix rows are written through
// cfg_we/cfg_index/cfg_wdata and are sampled at the multiply stage, so write
// them only while no item is in flight.
module vertex_transform_4x4
  import vt4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  vt4_in_t              in_item,
  output logic                 out_strobe,
  output vt4_out_t             out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]     cfg_wdata
);

  logic [ROW_W-1:0] row_r [LANES];
  logic [2:0]       valid_r;
  logic             accept;
  comp_vec_t        vec;
  vt4_lane_res_t    lane_res [LANES];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign vec[0] = in_item.in_x;
  assign vec[1] = in_item.in_y;
  assign vec[2] = in_item.in_z;
  assign vec[3] = in_item.in_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LANES; l++) begin
        row_r[l] <= ROW_RESET[l];
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ROW0: row_r[0] <= cfg_wdata;
        CFG_ROW1: row_r[1] <= cfg_wdata;
        CFG_ROW2: row_r[2] <= cfg_wdata;
        CFG_ROW3: row_r[3] <= cfg_wdata;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Track items through the three lane stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[1:0], accept};
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    vt4_lane u_lane (
      .clk   (clk),
      .coefs (row_r[l]),
      .vec   (vec),
      .res   (lane_res[l])
    );
  end

  vt4_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (valid_r[2]),
    .lane_res   (lane_res),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

@@ rtl/core/vt4_checker.sv @@
// Port-level checker for the vertex transform, bound to the top level.
// Depends on vt4_pkg and vertex_transform_4x4_assert.svh.
`include "vertex_transform_4x4_assert.svh"

module vt4_checker
  import vt4_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input vt4_out_t out_item
);

  logic accept;
  logic clip_seen;

  function automatic logic at_rail(logic [COMP_W-1:0] v);
    return (v == {1'b0, {(COMP_W-1){1'b1}}}) || (v == {1'b1, {(COMP_W-1){1'b0}}});
  endfunction

  assign accept    = start && !busy;
  assign clip_seen = at_rail(out_item.out_x) || at_rail(out_item.out_y) ||
                     at_rail(out_item.out_z) || at_rail(out_item.out_w);

  `VT4_ASSERT_NOW(a_accept_gives_result, accept, ##LATENCY out_strobe, "item gave no result")
  `VT4_ASSERT_NOW(a_result_has_item, out_strobe, $past(accept, LATENCY), "result without an item")
  `VT4_ASSERT_NOW(a_sat_clipped, out_strobe && out_item.saturated, clip_seen, "saturated, none clipped")
  `VT4_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking bench for vertex_transform_4x4: a directed table, then random phases.
// Depends on vt4_pkg and the vertex_transform_4x4 RTL; expectations: directed table or a local model.
`timescale 1ns / 1ps

module tb_top;
  import vt4_pkg::*;

  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     RANDOM_PHASES = 9;
  localparam int     PHASE_ITEMS  = 72;
  localparam int     MATRIX_KINDS = 5;
  localparam int     REPORT_MAX   = 10;
  localparam int     CFG_SPARE_LO = LANES;
  localparam int     CFG_SPARE_HI = (1 << CFG_IDX_W) - 1;
  localparam longint COMP_MAX     = (longint'(1) << (COMP_W - 1)) - 1;
  localparam longint COMP_MIN     = -(longint'(1) << (COMP_W - 1));

  localparam logic [COMP_W-1:0] V_MAX  = 32'h7fff_ffff;
  localparam logic [COMP_W-1:0] V_MIN  = 32'h8000_0000;
  localparam logic [COMP_W-1:0] V_ONES = 32'hffff_ffff;
  localparam logic [COMP_W-1:0] V_ZERO = 32'h0000_0000;

  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [ROW_W-1:0]     data;
    vt4_in_t              vertex;
    logic                 typed;
    vt4_out_t             want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  vt4_in_t              in_item;
  logic                 out_strobe;
  vt4_out_t             out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0]     cfg_wdata;

  logic [ROW_W-1:0] matrix_rows [LANES];
  vt4_out_t         transformed_vertices [$];
  stim_row_t        directed_steps [$];
  int               mismatches;
  int               idle_pct;

  vertex_transform_4x4 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Row dot vertex, exact sum, round half up, clip to 32 bits.
  function automatic vt4_out_t transform_vertex(vt4_in_t v);
    longint               comp [NCOL];
    longint               acc;
    longint               q;
    logic [COEF_W-1:0]    coef;
    logic [COMP_W-1:0]    lane [LANES];
    logic                 clipped;
    vt4_out_t             res;
    comp[0] = longint'($signed(v.in_x));
    comp[1] = longint'($signed(v.in_y));
    comp[2] = longint'($signed(v.in_z));
    comp[3] = longint'($signed(v.in_w));
    clipped = 1'b0;
    for (int r = 0; r < LANES; r++) begin
      acc = 0;
      for (int c = 0; c < NCOL; c++) begin
        coef = matrix_rows[r][c*COEF_W +: COEF_W];
        acc += longint'($signed(coef)) * comp[c];
      end
      q = (acc + ROUND_HALF) >>> FRAC_SHIFT;
      if (q > COMP_MAX) begin
        q = COMP_MAX;
        clipped = 1'b1;
      end
      if (q < COMP_MIN) begin
        q = COMP_MIN;
        clipped = 1'b1;
      end
      lane[r] = q[COMP_W-1:0];
    end
    res.out_x = lane[0];
    res.out_y = lane[1];
    res.out_z = lane[2];
    res.out_w = lane[3];
    res.saturated = clipped;
    return res;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic stim_row_t item_row(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                                         logic [COMP_W-1:0] z, logic [COMP_W-1:0] w);
    stim_row_t s;
    s = '{default: '0};
    s.vertex.in_x = x;
    s.vertex.in_y = y;
    s.vertex.in_z = z;
    s.vertex.in_w = w;
    return s;
  endfunction

  function automatic stim_row_t known_row(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                                          logic [COMP_W-1:0] z, logic [COMP_W-1:0] w,
                                          logic [COMP_W-1:0] ox, logic [COMP_W-1:0] oy,
                                          logic [COMP_W-1:0] oz, logic [COMP_W-1:0] ow,
                                          logic sat);
    stim_row_t s;
    s = item_row(x, y, z, w);
    s.typed = 1'b1;
    s.want.out_x = ox;
    s.want.out_y = oy;
    s.want.out_z = oz;
    s.want.out_w = ow;
    s.want.saturated = sat;
    return s;
  endfunction

  function automatic logic [COMP_W-1:0] pick_component();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return V_MAX;
          1: return V_MIN;
          2: return V_ZERO;
          3: return V_ONES;
          default: return 32'd1;
        endcase
      end
      1, 2, 3, 4: return $urandom;
      5, 6, 7: return 32'(int'($urandom_range(0, 2097151)) - 1048576);
      // land the sum close to a rounding tie
      8: return 32'((int'($urandom_range(0, 1023)) - 512) * 2048
                    + int'($urandom_range(0, 2)) - 1);
      default: return 32'(int'($urandom_range(0, 32)) - 16);
    endcase
  endfunction

  function automatic vt4_in_t random_vertex();
    vt4_in_t v;
    v.in_x = pick_component();
    v.in_y = pick_component();
    v.in_z = pick_component();
    v.in_w = pick_component();
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] make_row(int kind, int r);
    logic [ROW_W-1:0]  row;
    logic [COEF_W-1:0] c;
    if (kind == 0) return ROW_RESET[r];
    if (kind == 1) return {$urandom, $urandom};
    for (int col = 0; col < NCOL; col++) begin
      case (kind)
        2: c = 16'(int'($urandom_range(0, 8192)) - 4096);
        3: begin
          case ($urandom_range(0, 5))
            0: c = 16'h7fff;
            1: c = 16'h8000;
            2: c = 16'hffff;
            3: c = 16'h0000;
            4: c = 16'h0001;
            default: c = 16'h1000;
          endcase
        end
        default: begin
          // rotation-like: 0, +-1.0, +-0.707
          case ($urandom_range(0, 4))
            0: c = 16'h0000;
            1: c = 16'h1000;
            2: c = 16'hf000;
            3: c = 16'h0b50;
            default: c = 16'hf4b0;
          endcase
        end
      endcase
      row[col*COEF_W +: COEF_W] = c;
    end
    return row;
  endfunction

  // Hold start low until every strobed result has come back.
  task automatic quiesce();
    start <= 1'b0;
    while (transformed_vertices.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx < LANES) matrix_rows[idx] = data;
  endtask

  task automatic send_vertex(vt4_in_t v, logic typed, vt4_out_t want);
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_item <= random_vertex();
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    transformed_vertices.push_back(typed ? want : transform_vertex(v));
  endtask

  task automatic report_mismatch(string what, vt4_out_t want, vt4_out_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%s: expected x=%h y=%h z=%h w=%h sat=%b, got x=%h y=%h z=%h w=%h sat=%b",
               what, want.out_x, want.out_y, want.out_z, want.out_w, want.saturated,
               got.out_x, got.out_y, got.out_z, got.out_w, got.saturated);
  endtask

  always @(posedge clk) begin
    vt4_out_t want;
    if (rst_n && out_strobe) begin
      if (transformed_vertices.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_item);
      end else begin
        want = transformed_vertices.pop_front();
        if (out_item.out_x !== want.out_x || out_item.out_y !== want.out_y ||
            out_item.out_z !== want.out_z || out_item.out_w !== want.out_w ||
            out_item.saturated !== want.saturated)
          report_mismatch("vertex mismatch", want, out_item);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    stim_row_t s;
    vt4_out_t  none;
    none = '0;
    mismatches = 0;
    idle_pct = 27;
    for (int r = 0; r < LANES; r++) matrix_rows[r] = ROW_RESET[r];
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ROW0;
    cfg_wdata <= '0;

    // identity after reset: vertex passes straight through
    directed_steps.push_back(known_row(V_ZERO, V_ZERO, V_ZERO, V_ZERO,
                                       V_ZERO, V_ZERO, V_ZERO, V_ZERO, 1'b0));
    directed_steps.push_back(known_row(V_MAX, V_MIN, V_ZERO, V_ONES,
                                       V_MAX, V_MIN, V_ZERO, V_ONES, 1'b0));
    directed_steps.push_back(known_row(V_MIN, V_MAX, 32'd1, 32'h5555_5555,
                                       V_MIN, V_MAX, 32'd1, 32'h5555_5555, 1'b0));
    directed_steps.push_back(known_row(32'haaaa_aaaa, 32'h0001_0000, 32'hffff_0000, 32'h8000_0001,
                                       32'haaaa_aaaa, 32'h0001_0000, 32'hffff_0000, 32'h8000_0001,
                                       1'b0));
    // one-LSB rows for the ties, full-scale rows for clipping
    directed_steps.push_back(cfg_row(CFG_ROW0, 64'h0000_0000_0000_0001));
    directed_steps.push_back(cfg_row(CFG_ROW1, 64'h0000_0000_ffff_0000));
    directed_steps.push_back(cfg_row(CFG_ROW2, 64'h7fff_7fff_7fff_7fff));
    directed_steps.push_back(cfg_row(CFG_ROW3, 64'h8000_8000_8000_8000));
    directed_steps.push_back(known_row(32'hffff_f800, 32'h0000_0800, V_ZERO, V_ZERO,
                                       V_ZERO, V_ZERO, V_ZERO, V_ZERO, 1'b0));
    directed_steps.push_back(known_row(32'h0000_0800, 32'hffff_f800, V_ZERO, V_ZERO,
                                       32'd1, 32'd1, V_ZERO, V_ZERO, 1'b0));
    directed_steps.push_back(known_row(32'hffff_f7ff, 32'h0000_0801, V_ZERO, V_ZERO,
                                       V_ONES, V_ONES, V_ZERO, V_ZERO, 1'b0));
    directed_steps.push_back(known_row(V_MAX, V_MAX, V_MAX, V_MAX,
                                       32'h0008_0000, 32'hfff8_0000, V_MAX, V_MIN, 1'b1));
    directed_steps.push_back(known_row(V_MIN, V_MIN, V_MIN, V_MIN,
                                       32'hfff8_0000, 32'h0008_0000, V_MIN, V_MAX, 1'b1));
    directed_steps.push_back(item_row(V_MAX, V_MIN, V_MAX, V_MIN));
    directed_steps.push_back(item_row(32'h1234_5678, 32'hedcb_a988, 32'h0000_7fff, 32'hffff_8001));
    // a spare index must leave the matrix alone
    directed_steps.push_back(cfg_row(CFG_IDX_W'(CFG_SPARE_HI), '1));
    directed_steps.push_back(known_row(32'h0000_0800, 32'hffff_f800, V_ZERO, V_ZERO,
                                       32'd1, 32'd1, V_ZERO, V_ZERO, 1'b0));
    directed_steps.push_back(cfg_row(CFG_ROW0, '1));
    directed_steps.push_back(cfg_row(CFG_ROW1, '0));
    directed_steps.push_back(cfg_row(CFG_ROW2, 64'h8000_8000_8000_8000));
    directed_steps.push_back(cfg_row(CFG_ROW3, 64'h7fff_7fff_7fff_7fff));
    directed_steps.push_back(known_row(V_ZERO, V_ZERO, V_ZERO, V_ZERO,
                                       V_ZERO, V_ZERO, V_ZERO, V_ZERO, 1'b0));
    directed_steps.push_back(item_row(V_ONES, V_ONES, V_ONES, V_ONES));
    directed_steps.push_back(item_row(V_MAX, V_MIN, 32'd1, V_ONES));
    directed_steps.push_back(item_row(32'h0fed_cba9, 32'hf000_0fff, 32'h7654_3210, 32'h0000_8000));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.is_cfg) begin
        quiesce();
        write_cfg(s.idx, s.data);
      end else begin
        send_vertex(s.vertex, s.typed, s.want);
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        1: idle_pct = 64;
        3: idle_pct = 27;
        default: idle_pct = 0;
      endcase
      quiesce();
      for (int r = 0; r < LANES; r++)
        write_cfg(CFG_IDX_W'(r), make_row(phase % MATRIX_KINDS, r));
      if ($urandom_range(0, 1) == 1)
        write_cfg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), {$urandom, $urandom});
      for (int n = 0; n < PHASE_ITEMS; n++) send_vertex(random_vertex(), 1'b0, none);
    end

    quiesce();
    repeat (LATENCY * 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ vertex_transform_4x4.f @@
+incdir+rtl/core
rtl/core/vt4_pkg.sv
rtl/core/vt4_lane.sv
rtl/core/vt4_merge.sv
rtl/core/vertex_transform_4x4.sv
rtl/core/vt4_checker.sv
tb/sv/tb_top.sv
